### sv/csem_pkg.sv
// Shared types and constants for the counting semaphore table.
`timescale 1ns / 1ps

package csem_pkg;

    localparam int FUNC_W  = 3;
    localparam int ID_W    = 8;
    localparam int COUNT_W = 16;
    localparam int PID_W   = 8;

    localparam int DEF_TABLE_SIZE = 32;
    localparam int DEF_WAIT_DEPTH = 16;

    // Entries in the queue between the front and back parts.
    localparam int QUEUE_DEPTH = 2;

    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

    typedef enum logic [FUNC_W-1:0] {
        FN_INIT  = 3'd0,
        FN_OPEN  = 3'd1,
        FN_CLOSE = 3'd2,
        FN_WAIT  = 3'd3,
        FN_POST  = 3'd4
    } func_t;

    // Classified request as it travels from the front part to the back part.
    typedef struct packed {
        logic               bad;
        func_t              op;
        logic [ID_W-1:0]    id;
        logic [COUNT_W-1:0] init_value;
        logic [PID_W-1:0]   pid;
    } cmd_t;

endpackage

### sv/csem_req_if.sv
// Request channel: operation, semaphore id, start count and caller id.
`timescale 1ns / 1ps

interface csem_req_if;
    import csem_pkg::*;

    logic               valid;
    logic               ready;
    logic [FUNC_W-1:0]  func;
    logic [ID_W-1:0]    sem_id;
    logic [COUNT_W-1:0] init_value;
    logic [PID_W-1:0]   caller_pid;

    modport source (output valid, output func, output sem_id, output init_value,
                    output caller_pid, input ready);
    modport sink (input valid, input func, input sem_id, input init_value,
                  input caller_pid, output ready);
endinterface

### sv/csem_rsp_if.sv
// Response channel: status, block flag and wake-up report.
`timescale 1ns / 1ps

interface csem_rsp_if;
    import csem_pkg::*;

    logic             valid;
    logic             ready;
    logic             status;
    logic             must_block;
    logic             wake_valid;
    logic [PID_W-1:0] wake_pid;

    modport source (output valid, output status, output must_block, output wake_valid,
                    output wake_pid, input ready);
    modport sink (input valid, input status, input must_block, input wake_valid,
                  input wake_pid, output ready);
endinterface

### sv/csem_front.sv
// Front part: accepts requests, flags bad operations and ids, queues them.
`timescale 1ns / 1ps

module csem_front #(
    parameter int TABLE_SIZE = csem_pkg::DEF_TABLE_SIZE
) (
    input  logic              clk,
    input  logic              rst_n,
    csem_req_if.sink          req,
    output logic              q_valid,
    output csem_pkg::cmd_t    q_cmd,
    input  logic              q_ready
);
    import csem_pkg::*;

    localparam int QPTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

    cmd_t              q_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_next;
    logic [QCNT_W-1:0] cnt_reg;
    logic [QCNT_W-1:0] cnt_next;
    logic              push;
    logic              pop;
    cmd_t              new_cmd;

    assign req.ready = (cnt_reg != QCNT_W'(QUEUE_DEPTH));
    assign push      = req.valid && req.ready;
    assign q_valid   = (cnt_reg != '0);
    assign pop       = q_valid && q_ready;
    assign q_cmd     = q_mem[rd_ptr_reg];

    always_comb
    begin
        new_cmd.bad        = (req.func > FUNC_W'(FN_POST))
                             || ({1'b0, req.sem_id} >= (ID_W + 1)'(TABLE_SIZE));
        new_cmd.op         = func_t'(req.func);
        new_cmd.id         = req.sem_id;
        new_cmd.init_value = req.init_value;
        new_cmd.pid        = req.caller_pid;
    end

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_mem[wr_ptr_reg] <= new_cmd;
        end
    end

`ifndef NO_ASSERTIONS
    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= QCNT_W'(QUEUE_DEPTH))
        else $error("queue fill above depth");

    a_last_pop: assert property (@(posedge clk) disable iff (!rst_n)
        (pop && !push && cnt_reg == QCNT_W'(1)) |=> !q_valid)
        else $error("queue not empty after last item left");

    a_push_shows: assert property (@(posedge clk) disable iff (!rst_n)
        push |=> q_valid)
        else $error("pushed item not visible");
`endif

endmodule

### sv/csem_back.sv
// Back part: read-modify-write of one semaphore record and its wait queue.
`timescale 1ns / 1ps

module csem_back #(
    parameter int TABLE_SIZE = csem_pkg::DEF_TABLE_SIZE,
    parameter int WAIT_DEPTH = csem_pkg::DEF_WAIT_DEPTH
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              q_valid,
    input  csem_pkg::cmd_t    q_cmd,
    output logic              q_ready,
    csem_rsp_if.source        rsp
);
    import csem_pkg::*;

    localparam int IDX_W  = (TABLE_SIZE > 1) ? $clog2(TABLE_SIZE) : 1;
    localparam int HEAD_W = (WAIT_DEPTH > 1) ? $clog2(WAIT_DEPTH) : 1;
    localparam int FILL_W = $clog2(WAIT_DEPTH + 1);
    localparam int SUM_W  = FILL_W + 1;
    localparam int SLOTS  = TABLE_SIZE * WAIT_DEPTH;
    localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;

    typedef enum logic [1:0] {
        ST_READ = 2'b01,
        ST_EXEC = 2'b10
    } state_t;

    state_t state_reg;
    state_t state_next;

    // Per-entry record; in-use flags live in flip-flops, so the record
    // needs no reset: every entry is rewritten by init before it is used.
    logic [COUNT_W-1:0] count_mem [TABLE_SIZE];
    logic [HEAD_W-1:0]  head_mem  [TABLE_SIZE];
    logic [FILL_W-1:0]  fill_mem  [TABLE_SIZE];
    logic [PID_W-1:0]   pid_mem   [SLOTS];

    logic [COUNT_W-1:0] count_rd_reg;
    logic [HEAD_W-1:0]  head_rd_reg;
    logic [FILL_W-1:0]  fill_rd_reg;
    logic [PID_W-1:0]   pid_rd_reg;

    logic [TABLE_SIZE-1:0] in_use_reg;
    logic [TABLE_SIZE-1:0] in_use_next;

    cmd_t cmd_reg;

    logic out_valid_reg;
    logic out_valid_next;
    logic status_reg;
    logic block_reg;
    logic wake_reg;

    logic               rec_re;
    logic [IDX_W-1:0]   rd_idx;
    logic [IDX_W-1:0]   idx;
    logic               exec_go;
    logic               used;
    logic               rec_we;
    logic [COUNT_W-1:0] count_wr;
    logic [HEAD_W-1:0]  head_wr;
    logic [FILL_W-1:0]  fill_wr;
    logic               pid_we;
    logic               pid_re;
    logic [SUM_W-1:0]   tail_sum;
    logic [HEAD_W-1:0]  tail_pos;
    logic [HEAD_W-1:0]  head_inc;
    logic [SLOT_W-1:0]  slot;
    logic               status_c;
    logic               block_c;
    logic               wake_c;

    assign q_ready = (state_reg == ST_READ);
    assign rec_re  = q_valid && (state_reg == ST_READ);
    assign rd_idx  = q_cmd.id[IDX_W-1:0];
    assign idx     = cmd_reg.id[IDX_W-1:0];
    assign exec_go = (state_reg == ST_EXEC) && (!out_valid_reg || rsp.ready);
    assign used    = in_use_reg[idx];

    // Queue position of the new tail; head + fill stays below twice the depth.
    always_comb
    begin
        tail_sum = SUM_W'(head_rd_reg) + SUM_W'(fill_rd_reg);
        if (tail_sum >= SUM_W'(WAIT_DEPTH))
        begin
            tail_sum = tail_sum - SUM_W'(WAIT_DEPTH);
        end
        tail_pos = tail_sum[HEAD_W-1:0];
        head_inc = (head_rd_reg == HEAD_W'(WAIT_DEPTH - 1)) ? '0 : head_rd_reg + 1'b1;
    end

    always_comb
    begin
        rec_we      = 1'b0;
        count_wr    = count_rd_reg;
        head_wr     = head_rd_reg;
        fill_wr     = fill_rd_reg;
        pid_we      = 1'b0;
        pid_re      = 1'b0;
        in_use_next = in_use_reg;
        status_c    = 1'b1;
        block_c     = 1'b0;
        wake_c      = 1'b0;
        slot        = SLOT_W'(idx) * SLOT_W'(WAIT_DEPTH) + SLOT_W'(head_rd_reg);
        if (exec_go && !cmd_reg.bad)
        begin
            case (cmd_reg.op)
                FN_INIT:
                begin
                    if (!used)
                    begin
                        rec_we           = 1'b1;
                        count_wr         = cmd_reg.init_value;
                        head_wr          = '0;
                        fill_wr          = '0;
                        in_use_next[idx] = 1'b1;
                        status_c         = 1'b0;
                    end
                end
                FN_OPEN:
                begin
                    status_c = !used;
                end
                FN_CLOSE:
                begin
                    if (used)
                    begin
                        rec_we           = 1'b1;
                        count_wr         = '0;
                        head_wr          = '0;
                        fill_wr          = '0;
                        in_use_next[idx] = 1'b0;
                        status_c         = 1'b0;
                    end
                end
                FN_WAIT:
                begin
                    if (used)
                    begin
                        if (count_rd_reg != '0)
                        begin
                            rec_we   = 1'b1;
                            count_wr = count_rd_reg - 1'b1;
                            status_c = 1'b0;
                        end
                        else if (fill_rd_reg < FILL_W'(WAIT_DEPTH))
                        begin
                            // Queue the caller at the tail.
                            slot     = SLOT_W'(idx) * SLOT_W'(WAIT_DEPTH) + SLOT_W'(tail_pos);
                            pid_we   = 1'b1;
                            rec_we   = 1'b1;
                            fill_wr  = fill_rd_reg + 1'b1;
                            block_c  = 1'b1;
                            status_c = 1'b0;
                        end
                    end
                end
                FN_POST:
                begin
                    if (used)
                    begin
                        if (fill_rd_reg != '0)
                        begin
                            // Release the oldest waiter.
                            pid_re   = 1'b1;
                            rec_we   = 1'b1;
                            head_wr  = head_inc;
                            fill_wr  = fill_rd_reg - 1'b1;
                            wake_c   = 1'b1;
                            status_c = 1'b0;
                        end
                        else if (count_rd_reg != COUNT_MAX)
                        begin
                            rec_we   = 1'b1;
                            count_wr = count_rd_reg + 1'b1;
                            status_c = 1'b0;
                        end
                    end
                end
                default:
                begin
                    status_c = 1'b1;
                end
            endcase
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg;
        if (rsp.ready)
        begin
            out_valid_next = 1'b0;
        end
        case (state_reg)
            ST_READ:
            begin
                if (q_valid)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                if (exec_go)
                begin
                    state_next     = ST_READ;
                    out_valid_next = 1'b1;
                end
            end
            default:
            begin
                state_next = ST_READ;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_READ;
            out_valid_reg <= 1'b0;
            in_use_reg    <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            in_use_reg    <= in_use_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rec_re)
        begin
            cmd_reg <= q_cmd;
        end
        if (exec_go)
        begin
            status_reg <= status_c;
            block_reg  <= block_c;
            wake_reg   <= wake_c;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rec_we)
        begin
            count_mem[idx] <= count_wr;
            head_mem[idx]  <= head_wr;
            fill_mem[idx]  <= fill_wr;
        end
        if (rec_re)
        begin
            count_rd_reg <= count_mem[rd_idx];
            head_rd_reg  <= head_mem[rd_idx];
            fill_rd_reg  <= fill_mem[rd_idx];
        end
    end

    // The pid read only happens as a result is loaded, so pid_rd_reg holds
    // until that result is taken.
    always_ff @(posedge clk)
    begin
        if (pid_we)
        begin
            pid_mem[slot] <= cmd_reg.pid;
        end
        if (pid_re)
        begin
            pid_rd_reg <= pid_mem[slot];
        end
    end

    assign rsp.valid      = out_valid_reg;
    assign rsp.status     = status_reg;
    assign rsp.must_block = block_reg;
    assign rsp.wake_valid = wake_reg;
    assign rsp.wake_pid   = wake_reg ? pid_rd_reg : '0;

`ifndef NO_ASSERTIONS
    a_err_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && status_reg) |-> (!block_reg && !wake_reg))
        else $error("error result carries block or wake");

    a_block_xor_wake: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> !(block_reg && wake_reg))
        else $error("result both blocks and wakes");

    a_we_in_exec: assert property (@(posedge clk) disable iff (!rst_n)
        (rec_we || pid_we || pid_re) |-> (state_reg == ST_EXEC))
        else $error("record or queue access outside execute");

    a_pid_port: assert property (@(posedge clk) disable iff (!rst_n)
        !(pid_we && pid_re))
        else $error("queue memory read and written together");

    a_exec_done: assert property (@(posedge clk) disable iff (!rst_n)
        exec_go |=> (out_valid_reg && state_reg == ST_READ))
        else $error("executed request left no result");
`endif

endmodule

### sv/counting_semaphore_table.sv
// Counting semaphore table top level: front classifier/queue and back executor.
`timescale 1ns / 1ps

// Table of TABLE_SIZE counting semaphores, each with a 16-bit count, an in-use
// flag and a FIFO of up to WAIT_DEPTH waiting process ids. Every request gives
// exactly one response, in order. The back part handles each request with a
// registered read of the entry's count/head/fill record, then the update and
// the write-back; on a post that wakes a waiter the queue memory read lands
// in the same edge as the result. A two-entry queue in front lets requests
// arrive while a response is stalled. In-use flags are flip-flops cleared by
// reset, so the block is ready right after reset with no clearing pass. Ids
// at or above TABLE_SIZE and unknown operations answer with an error.
module counting_semaphore_table #(
    parameter int TABLE_SIZE = csem_pkg::DEF_TABLE_SIZE,
    parameter int WAIT_DEPTH = csem_pkg::DEF_WAIT_DEPTH
) (
    input  logic       clk,
    input  logic       rst_n,
    csem_req_if.sink   req,
    csem_rsp_if.source rsp
);
    import csem_pkg::*;

    logic q_valid;
    logic q_ready;
    cmd_t q_cmd;

    csem_front #(
        .TABLE_SIZE (TABLE_SIZE)
    ) u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (req),
        .q_valid (q_valid),
        .q_cmd   (q_cmd),
        .q_ready (q_ready)
    );

    csem_back #(
        .TABLE_SIZE (TABLE_SIZE),
        .WAIT_DEPTH (WAIT_DEPTH)
    ) u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_valid (q_valid),
        .q_cmd   (q_cmd),
        .q_ready (q_ready),
        .rsp     (rsp)
    );

endmodule
